[rtl/fud_pkg.sv]
package fud_pkg;

  localparam int FUD_QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_ONE     = 8'h31;

  typedef enum logic [1:0] {
    KIND_KEY       = 2'd0,
    KIND_VALUE     = 2'd1,
    KIND_KEY_END   = 2'd2,
    KIND_FIELD_END = 2'd3
  } fud_kind_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } fud_esc_t;

  typedef struct packed {
    fud_kind_t   kind;
    logic [7:0]  data;
    logic        bad;
    logic        last;
  } fud_result_t;

endpackage

[rtl/fud_step.sv]
module fud_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                is_final,
  output logic [1:0]          res_count,
  output fud_pkg::fud_result_t res0,
  output fud_pkg::fud_result_t res1
);
  import fud_pkg::*;

  logic       in_value_part;
  fud_esc_t   escape_phase;
  logic [3:0] high_nibble;
  logic       cut_seen;

  logic       in_value_part_next;
  fud_esc_t   escape_phase_next;
  logic [3:0] high_nibble_next;
  logic       cut_seen_next;

  fud_result_t first_res;
  fud_result_t close_res;
  logic        first_valid;
  logic [3:0]  nib;
  fud_kind_t   data_kind;

  // Digits '1'..'9', a..f, A..F; anything else, '0' included, gives zero.
  always_comb begin
    nib = 4'd0;
    if (in_byte inside {[CH_ONE : 8'h39]}) begin
      nib = 4'(in_byte - CH_ONE + 8'd1);
    end else if (in_byte inside {[CH_LOWER_A : 8'h66]}) begin
      nib = 4'(in_byte - CH_LOWER_A + 8'd10);
    end else if (in_byte inside {[CH_UPPER_A : 8'h46]}) begin
      nib = 4'(in_byte - CH_UPPER_A + 8'd10);
    end
  end

  always_comb begin
    in_value_part_next = in_value_part;
    escape_phase_next  = escape_phase;
    high_nibble_next   = high_nibble;
    cut_seen_next      = cut_seen;
    first_valid        = 1'b0;
    first_res          = '{kind: KIND_KEY, data: 8'd0, bad: 1'b0, last: 1'b0};
    data_kind          = in_value_part ? KIND_VALUE : KIND_KEY;

    if (in_byte == CH_AMP) begin
      first_valid         = 1'b1;
      first_res.kind      = KIND_FIELD_END;
      first_res.bad       = cut_seen | (escape_phase != ESC_NONE);
      in_value_part_next  = 1'b0;
      escape_phase_next   = ESC_NONE;
      high_nibble_next    = 4'd0;
      cut_seen_next       = 1'b0;
    end else if (in_byte == CH_EQUALS && !in_value_part) begin
      first_valid         = 1'b1;
      first_res.kind      = KIND_KEY_END;
      cut_seen_next       = cut_seen | (escape_phase != ESC_NONE);
      escape_phase_next   = ESC_NONE;
      high_nibble_next    = 4'd0;
      in_value_part_next  = 1'b1;
    end else begin
      case (escape_phase)
        ESC_HIGH: begin
          high_nibble_next  = nib;
          escape_phase_next = ESC_LOW;
        end
        ESC_LOW: begin
          first_valid       = 1'b1;
          first_res.kind    = data_kind;
          first_res.data    = {high_nibble, nib};
          escape_phase_next = ESC_NONE;
          high_nibble_next  = 4'd0;
        end
        default: begin
          if (in_byte == CH_PERCENT) begin
            escape_phase_next = ESC_HIGH;
            high_nibble_next  = 4'd0;
          end else begin
            first_valid    = 1'b1;
            first_res.kind = data_kind;
            first_res.data = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
          end
        end
      endcase
    end

    // The final byte closes whatever field is left after the byte itself.
    close_res = '{kind: KIND_FIELD_END, data: 8'd0,
                  bad: cut_seen_next | (escape_phase_next != ESC_NONE), last: 1'b1};
    if (is_final) begin
      in_value_part_next = 1'b0;
      escape_phase_next  = ESC_NONE;
      high_nibble_next   = 4'd0;
      cut_seen_next      = 1'b0;
    end

    first_res.last = !is_final;
    res_count      = {1'b0, first_valid} + {1'b0, is_final};
    res0           = first_valid ? first_res : close_res;
    res1           = close_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_value_part <= 1'b0;
      escape_phase  <= ESC_NONE;
      high_nibble   <= 4'd0;
      cut_seen      <= 1'b0;
    end else if (accept) begin
      in_value_part <= in_value_part_next;
      escape_phase  <= escape_phase_next;
      high_nibble   <= high_nibble_next;
      cut_seen      <= cut_seen_next;
    end
  end

endmodule

[rtl/fud_queue.sv]
module fud_queue #(
  parameter int DEPTH = fud_pkg::FUD_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           push_count,
  input  fud_pkg::fud_result_t wr0,
  input  fud_pkg::fud_result_t wr1,
  output logic                 room_for_two,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output fud_pkg::fud_result_t rd_data
);
  import fud_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  fud_result_t entries [DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [CW-1:0] count;
  logic          pop;
  logic [PW-1:0] tail_plus_one;

  assign pop           = rd_valid && rd_ready;
  assign rd_valid      = (count != '0);
  assign rd_data       = entries[head];
  assign room_for_two  = (count <= CW'(DEPTH - 2));
  assign tail_plus_one = tail + PW'(1);

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[tail] <= wr0;
    end
    if (push_count == 2'd2) begin
      entries[tail_plus_one] <= wr1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + PW'(push_count);
      head  <= head + PW'(pop);
      count <= count + CW'(push_count) - CW'(pop);
    end
  end

endmodule

[rtl/form_urlencoded_field_decoder_core.sv]
// Results are registered in the result queue before they leave the core.
// Throughput: one input beat per cycle while results are drained as fast as
// they are made; the two results of one beat leave one after the other, and
// the result queue absorbs the difference until fewer than two slots are free.
// Reset (rst, synchronous, active high) returns to key parsing with no escape
// pending and empties the result queue.
module form_urlencoded_field_decoder_core #(
  parameter int QUEUE_DEPTH = fud_pkg::FUD_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       is_final,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       bad_escape,
  output logic       last_of_run
);
  import fud_pkg::*;

  logic        accept;
  logic [1:0]  res_count;
  logic [1:0]  push_count;
  fud_result_t res0;
  fud_result_t res1;
  fud_result_t head_res;
  logic        room_for_two;

  assign in_ready   = room_for_two;
  assign accept     = in_valid && in_ready;
  assign push_count = accept ? res_count : 2'd0;

  fud_step u_step (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .is_final  (is_final),
    .res_count (res_count),
    .res0      (res0),
    .res1      (res1)
  );

  fud_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk          (clk),
    .rst          (rst),
    .push_count   (push_count),
    .wr0          (res0),
    .wr1          (res1),
    .room_for_two (room_for_two),
    .rd_valid     (out_valid),
    .rd_ready     (out_ready),
    .rd_data      (head_res)
  );

  assign out_kind    = head_res.kind;
  assign out_byte    = head_res.data;
  assign bad_escape  = head_res.bad;
  assign last_of_run = head_res.last;

endmodule

[sim/tb_form_urlencoded_field_decoder_core.sv]
module tb_form_urlencoded_field_decoder_core;
  import fud_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int HOLD_START   = 300;
  localparam int HOLD_CYCLES  = 80;
  localparam int QUIET_START  = 700;
  localparam int QUIET_END    = 1000;
  localparam int BODY_BYTES   = 1100;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [7:0] raw;
    logic       fin;
    bit         drain;
  } body_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       is_final = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       bad_escape;
  logic       last_of_run;

  body_item_t  body_bytes[$];
  fud_result_t expected_tokens[$];

  // Decoder state as the scoreboard sees it.
  logic       in_value;
  fud_esc_t   esc_phase;
  logic [3:0] hi_nib;
  logic       cut_seen;
  fud_result_t step_buf[2];
  int          step_n;

  logic       in_fire = 1'b0;
  int         run_cycles = 0;
  int         stall_cycles = 0;
  int         hold_left = 0;
  int         mismatches = 0;
  logic       quiet;
  logic       offer;
  body_item_t cur;
  fud_result_t cur_tok;

  string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_.~";
  string hexset = "0123456789abcdefABCDEF";

  form_urlencoded_field_decoder_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .is_final   (is_final),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_kind   (out_kind),
    .out_byte   (out_byte),
    .bad_escape (bad_escape),
    .last_of_run(last_of_run)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [3:0] hex_nibble(logic [7:0] c);
    if (c >= CH_ONE && c <= CH_ONE + 8'd8) return 4'(c - CH_ONE + 8'd1);
    if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5) return 4'(c - CH_LOWER_A + 8'd10);
    if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5) return 4'(c - CH_UPPER_A + 8'd10);
    return 4'd0;
  endfunction

  task automatic add_result(fud_kind_t k, logic [7:0] d, logic b);
    step_buf[step_n].kind = k;
    step_buf[step_n].data = d;
    step_buf[step_n].bad  = b;
    step_buf[step_n].last = 1'b0;
    step_n++;
  endtask

  task automatic close_field();
    add_result(KIND_FIELD_END, 8'h00, cut_seen || (esc_phase != ESC_NONE));
    in_value  = 1'b0;
    esc_phase = ESC_NONE;
    hi_nib    = 4'd0;
    cut_seen  = 1'b0;
  endtask

  task automatic decode_byte(logic [7:0] c, logic fin);
    fud_kind_t   dk;
    fud_result_t r;
    step_n = 0;
    if (c == CH_AMP) begin
      close_field();
    end else if (c == CH_EQUALS && !in_value) begin
      // An escape still open in the key is dropped and remembered for the field end.
      if (esc_phase != ESC_NONE) cut_seen = 1'b1;
      esc_phase = ESC_NONE;
      hi_nib    = 4'd0;
      add_result(KIND_KEY_END, 8'h00, 1'b0);
      in_value = 1'b1;
    end else begin
      dk = in_value ? KIND_VALUE : KIND_KEY;
      case (esc_phase)
        ESC_HIGH: begin
          hi_nib    = hex_nibble(c);
          esc_phase = ESC_LOW;
        end
        ESC_LOW: begin
          add_result(dk, {hi_nib, hex_nibble(c)}, 1'b0);
          esc_phase = ESC_NONE;
          hi_nib    = 4'd0;
        end
        default: begin
          if (c == CH_PERCENT) begin
            esc_phase = ESC_HIGH;
            hi_nib    = 4'd0;
          end else if (c == CH_PLUS) begin
            add_result(dk, CH_SPACE, 1'b0);
          end else begin
            add_result(dk, c, 1'b0);
          end
        end
      endcase
    end
    if (fin) close_field();
    for (int i = 0; i < step_n; i++) begin
      r = step_buf[i];
      r.last = (i == step_n - 1);
      expected_tokens.push_back(r);
    end
  endtask

  task automatic check_field(string what, int got, int want);
    if (got != want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  task automatic add_byte(logic [7:0] b, logic fin);
    body_item_t it;
    it.raw   = b;
    it.fin   = fin;
    it.drain = 1'b0;
    body_bytes.push_back(it);
  endtask

  task automatic add_drain();
    body_item_t it;
    it.raw   = 8'h00;
    it.fin   = 1'b0;
    it.drain = 1'b1;
    body_bytes.push_back(it);
  endtask

  task automatic add_text(string s, logic fin_last);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], fin_last && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] hex_char();
    if ($urandom_range(0, 99) < 90) return hexset[$urandom_range(0, hexset.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  // A run of key or value text: mostly clean characters and escapes, some noise.
  task automatic add_run(int n);
    int  pick;
    logic stray_fin;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      stray_fin = ($urandom_range(0, 199) == 0);
      if (pick < 60) begin
        add_byte(alnum[$urandom_range(0, alnum.len() - 1)], stray_fin);
      end else if (pick < 70) begin
        add_byte(CH_PLUS, stray_fin);
      end else if (pick < 88) begin
        add_byte(CH_PERCENT, 1'b0);
        add_byte(hex_char(), 1'b0);
        add_byte(hex_char(), stray_fin);
      end else if (pick < 93) begin
        add_byte(CH_PERCENT, 1'b0);
        add_byte(hex_char(), stray_fin);
      end else begin
        add_byte(8'($urandom_range(0, 255)), stray_fin);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_fire      <= 1'b0;
      run_cycles   <= 0;
      stall_cycles <= 0;
      in_value      = 1'b0;
      esc_phase     = ESC_NONE;
      hi_nib        = 4'd0;
      cut_seen      = 1'b0;
    end else begin
      run_cycles <= run_cycles + 1;
      in_fire    <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual kind %0d byte %0h",
                   $time, out_kind, out_byte);
          mismatches++;
        end else begin
          cur_tok = expected_tokens.pop_front();
          check_field("out_kind", int'(out_kind), int'(cur_tok.kind));
          check_field("out_byte", int'(out_byte), int'(cur_tok.data));
          check_field("bad_escape", int'(bad_escape), int'(cur_tok.bad));
          check_field("last_of_run", int'(last_of_run), int'(cur_tok.last));
        end
      end
      if (in_valid && in_ready) decode_byte(in_byte, is_final);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("tb_form_urlencoded_field_decoder_core NOT OK");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  assign quiet = (run_cycles >= QUIET_START) && (run_cycles < QUIET_END);

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      offer = 1'b0;
      // A drain mark holds the sender back until every result is out.
      if (body_bytes.size() > 0 && body_bytes[0].drain && expected_tokens.size() == 0)
        void'(body_bytes.pop_front());
      if (body_bytes.size() > 0 && !body_bytes[0].drain &&
          (quiet || $urandom_range(0, 99) >= 10)) begin
        cur = body_bytes.pop_front();
        in_byte  <= cur.raw;
        is_final <= cur.fin;
        offer = 1'b1;
      end
      in_valid <= offer;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (run_cycles == HOLD_START) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(0, 99) >= 10);
      end
    end
  end

  initial begin
    int  nf;
    bit  drained;
    drained = 1'b0;

    // Directed bodies: separators, plus, escapes cut by each separator and by the end.
    add_text("a=+&", 1'b0);
    add_text("%4=%=1&", 1'b0);
    add_text("%4&", 1'b0);
    add_text("x&", 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_text("%fF", 1'b0);
    add_text("%A", 1'b1);
    add_text("&", 1'b1);
    add_drain();

    while (body_bytes.size() < BODY_BYTES) begin
      nf = $urandom_range(1, 4);
      for (int f = 0; f < nf; f++) begin
        if (f > 0) add_byte(CH_AMP, 1'b0);
        add_run($urandom_range(0, 4));
        if ($urandom_range(0, 99) < 80) begin
          add_byte(CH_EQUALS, 1'b0);
          add_run($urandom_range(0, 5));
        end
      end
      if ($urandom_range(0, 3) == 0) add_byte(CH_AMP, 1'b1);
      else add_byte(alnum[$urandom_range(0, alnum.len() - 1)], 1'b1);
      if (!drained && body_bytes.size() > BODY_BYTES / 2) begin
        add_drain();
        drained = 1'b1;
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (body_bytes.size() > 0 || in_valid) @(posedge clk);
    while (expected_tokens.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_form_urlencoded_field_decoder_core OK");
    end else begin
      $display("tb_form_urlencoded_field_decoder_core NOT OK");
    end
    $finish;
  end

endmodule
